[hw/rtl/iaf_pkg.sv]
// ----------------------------------------------------------------------------
// Integer-to-ASCII formatter package
// Conversion codes, sequencer states, ASCII constants and digit helpers.
// ----------------------------------------------------------------------------
package iaf_pkg;

  typedef enum logic [1:0] {
    OP_SDEC = 2'd0,
    OP_UDEC = 2'd1,
    OP_HEXL = 2'd2,
    OP_HEXU = 2'd3
  } op_e;

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_CONV      = 7'b0000010,
    ST_NORM      = 7'b0000100,
    ST_SIGN_LEAD = 7'b0001000,
    ST_PAD_PRE   = 7'b0010000,
    ST_SIGN      = 7'b0100000,
    ST_DIGIT     = 7'b1000000
  } state_e;

  // post-pad is a separate flag-free state kept outside the enum above
  typedef enum logic [1:0] {
    TAIL_NONE = 2'b01,
    TAIL_PAD  = 2'b10
  } tail_e;

  localparam int unsigned NumDigits = 10;
  localparam int unsigned DigW      = 4 * NumDigits;
  localparam int unsigned ValueW    = 32;

  localparam logic [6:0] AsciiMinus = 7'h2D;
  localparam logic [6:0] AsciiSpace = 7'h20;
  localparam logic [6:0] AsciiZero  = 7'h30;
  localparam logic [6:0] AsciiUpA   = 7'h41;
  localparam logic [6:0] AsciiLowA  = 7'h61;

  // one hex or decimal digit to its ASCII code
  function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
    logic [6:0] base;
    begin
      if (d < 4'd10) begin
        digit_char = AsciiZero + {3'b000, d};
      end else begin
        base       = upper ? AsciiUpA : AsciiLowA;
        digit_char = base + {3'b000, d} - 7'd10;
      end
    end
  endfunction

  // double-dabble correction of one BCD digit before the shift
  function automatic logic [3:0] bcd_adj(input logic [3:0] d);
    begin
      bcd_adj = (d >= 4'd5) ? d + 4'd3 : d;
    end
  endfunction

endpackage

[hw/rtl/integer_to_ascii_formatter_top.sv]
// ----------------------------------------------------------------------------
// Integer-to-ASCII formatter
// printf-style integer field: bit-serial binary-to-BCD (decimal only), digit normalize,
// then one character per cycle while the output is not stalled, with sign and pad placement.
// ----------------------------------------------------------------------------
// Sequencing: decimal items pass through the bit-serial BCD converter, hex
//   items skip it; leading-zero strip removes one digit per cycle.
// Throughput: one character per cycle once emitting, while out_ready_i allows;
//   a new item is accepted only after the previous item's last character is emitted.
// Reset: rst_ni is asynchronous, active low; clears the sequencer and the
//   output valid. Digit and payload registers are not reset.
module integer_to_ascii_formatter_top
  import iaf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] value_i,
  input  logic [5:0]  field_width_i,
  input  logic        zero_pad_i,
  input  logic        left_align_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  character_o,
  output logic        last_o
);

  state_e            state_q, state_d;
  tail_e             tail_q, tail_d;
  logic [4:0]        bit_cnt_q, bit_cnt_d;
  logic [ValueW-1:0] bin_q, bin_d;
  logic [DigW-1:0]   dig_q, dig_d;
  logic [3:0]        ndig_q, ndig_d;
  logic [5:0]        pad_q, pad_d;
  logic [5:0]        fw_q;
  logic              neg_q, sf_q, left_q, zpad_q, hex_q, upper_q;
  logic              out_valid_q, out_valid_d;
  logic [6:0]        char_q, char_d;
  logic              last_q, last_d;

  logic              in_xfer;
  logic              out_free;
  logic              in_neg;
  logic [ValueW-1:0] in_mag;
  logic [DigW-1:0]   dig_adj;
  logic [5:0]        tot_len;
  logic [5:0]        pad_calc;
  logic              emit;
  logic [6:0]        emit_char;
  logic              emit_last;

  assign in_ready_o = (state_q == ST_IDLE) && (tail_q == TAIL_NONE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign in_neg = (op_e'(op_i) == OP_SDEC) && value_i[ValueW-1];
  assign in_mag = in_neg ? (~value_i + 32'd1) : value_i;

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      dig_adj[4*i +: 4] = bcd_adj(dig_q[4*i +: 4]);
    end
  end

  // characters before padding: digits plus a sign wherever it goes
  assign tot_len  = {2'b00, ndig_q} + {5'b0, neg_q};
  assign pad_calc = (fw_q > tot_len) ? (fw_q - tot_len) : 6'd0;

  always_comb begin
    state_d     = state_q;
    tail_d      = tail_q;
    bit_cnt_d   = bit_cnt_q;
    bin_d       = bin_q;
    dig_d       = dig_q;
    ndig_d      = ndig_q;
    pad_d       = pad_q;
    emit        = 1'b0;
    emit_char   = AsciiSpace;
    emit_last   = 1'b0;

    if (tail_q == TAIL_PAD) begin
      // trailing spaces of a left-aligned field
      if (out_free) begin
        emit      = 1'b1;
        emit_char = AsciiSpace;
        emit_last = (pad_q == 6'd1);
        pad_d     = pad_q - 6'd1;
        if (pad_q == 6'd1) begin
          tail_d = TAIL_NONE;
        end
      end
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            bit_cnt_d = '0;
            ndig_d    = 4'(NumDigits);
            if (op_i[1]) begin
              dig_d   = {{(DigW-ValueW){1'b0}}, in_mag};
              state_d = ST_NORM;
            end else begin
              bin_d   = in_mag;
              dig_d   = '0;
              state_d = ST_CONV;
            end
          end
        end
        ST_CONV: begin
          dig_d     = {dig_adj[DigW-2:0], bin_q[ValueW-1]};
          bin_d     = {bin_q[ValueW-2:0], 1'b0};
          bit_cnt_d = bit_cnt_q + 5'd1;
          if (bit_cnt_q == 5'd31) begin
            state_d = ST_NORM;
          end
        end
        ST_NORM: begin
          if ((dig_q[DigW-1 -: 4] == 4'd0) && (ndig_q != 4'd1)) begin
            dig_d  = {dig_q[DigW-5:0], 4'd0};
            ndig_d = ndig_q - 4'd1;
          end else begin
            pad_d = pad_calc;
            if (sf_q) begin
              state_d = ST_SIGN_LEAD;
            end else if (!left_q && (pad_calc != 6'd0)) begin
              state_d = ST_PAD_PRE;
            end else if (neg_q) begin
              state_d = ST_SIGN;
            end else begin
              state_d = ST_DIGIT;
            end
          end
        end
        ST_SIGN_LEAD: begin
          if (out_free) begin
            emit      = 1'b1;
            emit_char = AsciiMinus;
            state_d   = (pad_q != 6'd0) ? ST_PAD_PRE : ST_DIGIT;
          end
        end
        ST_PAD_PRE: begin
          if (out_free) begin
            emit      = 1'b1;
            emit_char = zpad_q ? AsciiZero : AsciiSpace;
            pad_d     = pad_q - 6'd1;
            if (pad_q == 6'd1) begin
              state_d = (neg_q && !sf_q) ? ST_SIGN : ST_DIGIT;
            end
          end
        end
        ST_SIGN: begin
          if (out_free) begin
            emit      = 1'b1;
            emit_char = AsciiMinus;
            state_d   = ST_DIGIT;
          end
        end
        ST_DIGIT: begin
          if (out_free) begin
            emit      = 1'b1;
            emit_char = digit_char(dig_q[DigW-1 -: 4], upper_q);
            dig_d     = {dig_q[DigW-5:0], 4'd0};
            ndig_d    = ndig_q - 4'd1;
            if (ndig_q == 4'd1) begin
              state_d = ST_IDLE;
              if (left_q && (pad_q != 6'd0)) begin
                tail_d = TAIL_PAD;
              end else begin
                emit_last = 1'b1;
              end
            end
          end
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      char_d      = emit_char;
      last_d      = emit_last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tail_q      <= TAIL_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_cnt_q <= bit_cnt_d;
    bin_q     <= bin_d;
    dig_q     <= dig_d;
    ndig_q    <= ndig_d;
    pad_q     <= pad_d;
    char_q    <= char_d;
    last_q    <= last_d;
    if (in_xfer) begin
      fw_q    <= field_width_i;
      neg_q   <= in_neg;
      sf_q    <= in_neg && zero_pad_i && !left_align_i;
      left_q  <= left_align_i;
      zpad_q  <= zero_pad_i;
      hex_q   <= op_i[1];
      upper_q <= (op_e'(op_i) == OP_HEXU);
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

`ifndef NO_ASSERTIONS
  // BCD digits never exceed nine once conversion is done
  a_bcd_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIGIT) && !hex_q |-> dig_q[DigW-1 -: 4] <= 4'd9)
    else $error("decimal digit out of range");

  // digit count stays within the converter's width while in use
  a_ndig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NORM) || (state_q == ST_DIGIT) |->
      (ndig_q != 4'd0) && (ndig_q <= 4'(NumDigits)))
    else $error("digit count out of range");

  // a pad state is only entered with pad left to send
  a_pad_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PAD_PRE) || (tail_q == TAIL_PAD) |-> pad_q != 6'd0)
    else $error("pad state with empty pad count");

  // hex items bypass the BCD converter
  a_hex_no_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && op_i[1] |=> state_q == ST_NORM)
    else $error("hex transfer did not go straight to normalize");
`endif

endmodule
